[src/jbt_pkg.sv]
// ----------------------------------------------------------------------------
// jbt_pkg: shared types and constants of the JSON byte tokenizer
// Token kinds, error codes, lexer state and result word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package jbt_pkg;

   localparam int VALUE_W    = 63;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [VALUE_W-1:0] VAL_MAX = {VALUE_W{1'b1}};

   localparam logic [3:0] KIND_OBJ_BEGIN = 4'd0;
   localparam logic [3:0] KIND_OBJ_END   = 4'd1;
   localparam logic [3:0] KIND_ARR_BEGIN = 4'd2;
   localparam logic [3:0] KIND_ARR_END   = 4'd3;
   localparam logic [3:0] KIND_COLON     = 4'd4;
   localparam logic [3:0] KIND_COMMA     = 4'd5;
   localparam logic [3:0] KIND_STR_START = 4'd6;
   localparam logic [3:0] KIND_STR_CHAR  = 4'd7;
   localparam logic [3:0] KIND_STR_END   = 4'd8;
   localparam logic [3:0] KIND_INT       = 4'd9;
   localparam logic [3:0] KIND_FLOAT     = 4'd10;
   localparam logic [3:0] KIND_TRUE      = 4'd11;
   localparam logic [3:0] KIND_FALSE     = 4'd12;
   localparam logic [3:0] KIND_NULL      = 4'd13;
   localparam logic [3:0] KIND_ERROR     = 4'd14;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_COMMENT    = 3'd1;
   localparam logic [2:0] ERR_STRING     = 3'd2;
   localparam logic [2:0] ERR_DOT        = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN    = 3'd4;
   localparam logic [2:0] ERR_SLASH      = 3'd5;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_LINE,
      MODE_STR,
      MODE_STR_ESC,
      MODE_STR_HEX,
      MODE_NUM,
      MODE_KW
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [VALUE_W-1:0] acc;
      logic [1:0]         fphase;
      logic [2:0]         hex_cnt;
      logic [15:0]        hex_acc;
      logic [2:0]         kw_prog;
      logic [1:0]         kw_which;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode: MODE_IDLE, acc: '0, fphase: '0, hex_cnt: '0,
      hex_acc: '0, kw_prog: '0, kw_which: '0};

   typedef struct packed {
      logic [3:0]         kind;
      logic [VALUE_W-1:0] value;
      logic [2:0]         err;
      logic               last;
   } res_type;

   localparam res_type RES_NONE = '{kind: '0, value: '0, err: '0, last: 1'b0};

   function automatic res_type mk_res(logic [3:0] kind, logic [VALUE_W-1:0] value,
                                      logic [2:0] err);
      res_type r;
      r.kind  = kind;
      r.value = value;
      r.err   = err;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] w);
      logic [2:0] len;
      case (w)
         2'd1:    len = 3'd5;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (w)
         2'd0: begin
            case (p)
               3'd0:    c = "t";
               3'd1:    c = "r";
               3'd2:    c = "u";
               3'd3:    c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (p)
               3'd0:    c = "f";
               3'd1:    c = "a";
               3'd2:    c = "l";
               3'd3:    c = "s";
               3'd4:    c = "e";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (p)
               3'd0:    c = "n";
               3'd1:    c = "u";
               3'd2:    c = "l";
               3'd3:    c = "l";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[src/jbt_lexer.sv]
// ----------------------------------------------------------------------------
// jbt_lexer: lexer state and per-byte token logic
// Consumes one registered byte per step, updates the lexer state and
// produces up to two result words.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_lexer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_fire,
   input  wire logic [7:0]       step_byte,
   input  wire logic             step_end,
   output jbt_pkg::res_type      res0,
   output jbt_pkg::res_type      res1,
   output logic [1:0]            res_count
);
   import jbt_pkg::*;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic      emit;
      res_type   r;
      mode_type  mode;
      logic      kw;
      logic [1:0] kw_which;
      logic      num;
   } idle_type;

   typedef struct packed {
      logic     emit;
      res_type  r;
      mode_type mode;
   } str_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic idle_type idle_fn(logic [7:0] b);
      idle_type o;
      o.emit     = 1'b0;
      o.r        = RES_NONE;
      o.mode     = MODE_IDLE;
      o.kw       = 1'b0;
      o.kw_which = 2'd0;
      o.num      = 1'b0;
      case (b)
         CH_SPACE, CH_TAB, CH_LF, CH_CR: o.mode = MODE_IDLE;
         CH_SLASH: o.mode = MODE_SLASH;
         "{": begin o.emit = 1'b1; o.r = mk_res(KIND_OBJ_BEGIN, '0, ERR_NONE); end
         "}": begin o.emit = 1'b1; o.r = mk_res(KIND_OBJ_END, '0, ERR_NONE); end
         "[": begin o.emit = 1'b1; o.r = mk_res(KIND_ARR_BEGIN, '0, ERR_NONE); end
         "]": begin o.emit = 1'b1; o.r = mk_res(KIND_ARR_END, '0, ERR_NONE); end
         ":": begin o.emit = 1'b1; o.r = mk_res(KIND_COLON, '0, ERR_NONE); end
         ",": begin o.emit = 1'b1; o.r = mk_res(KIND_COMMA, '0, ERR_NONE); end
         CH_QUOTE: begin
            o.emit = 1'b1;
            o.r    = mk_res(KIND_STR_START, '0, ERR_NONE);
            o.mode = MODE_STR;
         end
         "t": begin o.mode = MODE_KW; o.kw = 1'b1; o.kw_which = 2'd0; end
         "f": begin o.mode = MODE_KW; o.kw = 1'b1; o.kw_which = 2'd1; end
         "n": begin o.mode = MODE_KW; o.kw = 1'b1; o.kw_which = 2'd2; end
         default: begin
            if (is_digit(b)) begin
               o.mode = MODE_NUM;
               o.num  = 1'b1;
            end else begin
               o.emit = 1'b1;
               o.r    = mk_res(KIND_ERROR, '0, ERR_UNKNOWN);
            end
         end
      endcase
      return o;
   endfunction

   function automatic str_type str_fn(logic [7:0] b);
      str_type o;
      o.emit = 1'b0;
      o.r    = RES_NONE;
      o.mode = MODE_STR;
      if (b == CH_BSLASH) begin
         o.mode = MODE_STR_ESC;
      end else if (b == CH_QUOTE) begin
         o.emit = 1'b1;
         o.r    = mk_res(KIND_STR_END, '0, ERR_NONE);
         o.mode = MODE_IDLE;
      end else begin
         o.emit = 1'b1;
         o.r    = mk_res(KIND_STR_CHAR, VALUE_W'(b), ERR_NONE);
      end
      return o;
   endfunction

   state_type st_ff, st_in;
   res_type   res_a [2];
   logic [1:0] n_res;

   always_comb begin
      idle_type           ib;
      str_type            sb;
      logic               dig;
      logic [3:0]         dval;
      logic [VALUE_W+3:0] mac;
      logic               hex_ok;
      logic [3:0]         hex_d;
      logic [15:0]        hacc_new;
      logic [2:0]         hcnt_new;
      logic [1:0]         w;
      logic [2:0]         p;
      logic [2:0]         p_new;

      ib    = idle_fn(step_byte);
      sb    = str_fn(step_byte);
      dig   = is_digit(step_byte);
      dval  = step_byte[3:0];
      mac   = ({4'b0, st_ff.acc} << 3) + ({4'b0, st_ff.acc} << 1)
              + {{VALUE_W{1'b0}}, dval};
      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (dig) begin
         hex_d = step_byte[3:0];
      end else if (step_byte >= "a" && step_byte <= "f") begin
         hex_d = 4'(step_byte - "a" + 8'd10);
      end else if (step_byte >= "A" && step_byte <= "F") begin
         hex_d = 4'(step_byte - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
      hacc_new = {st_ff.hex_acc[11:0], hex_d};
      hcnt_new = st_ff.hex_cnt + 3'd1;
      w        = (st_ff.kw_which == 2'd3) ? 2'd2 : st_ff.kw_which;
      p        = st_ff.kw_prog;
      p_new    = p + 3'd1;

      st_in    = st_ff;
      res_a[0] = RES_NONE;
      res_a[1] = RES_NONE;
      n_res    = 2'd0;

      if (step_end) begin
         case (st_ff.mode)
            MODE_SLASH: begin
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_SLASH); n_res = n_res + 2'd1;
            end
            MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE: begin
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_COMMENT); n_res = n_res + 2'd1;
            end
            MODE_STR: begin
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_STRING); n_res = n_res + 2'd1;
            end
            MODE_STR_ESC: begin
               res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_BSLASH), ERR_NONE);
               n_res = n_res + 2'd1;
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_STRING); n_res = n_res + 2'd1;
            end
            MODE_STR_HEX: begin
               res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(st_ff.hex_acc), ERR_NONE);
               n_res = n_res + 2'd1;
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_STRING); n_res = n_res + 2'd1;
            end
            MODE_NUM: begin
               if (st_ff.fphase == 2'd1) begin
                  res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_DOT);
               end else begin
                  res_a[n_res[0]] = mk_res((st_ff.fphase == 2'd0) ? KIND_INT : KIND_FLOAT,
                                           st_ff.acc, ERR_NONE);
               end
               n_res = n_res + 2'd1;
            end
            MODE_KW: begin
               res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_UNKNOWN); n_res = n_res + 2'd1;
            end
            default: ;
         endcase
         st_in = STATE_RESET;
      end else begin
         case (st_ff.mode)
            MODE_SLASH: begin
               if (step_byte == CH_STAR) begin
                  st_in.mode = MODE_BLOCK;
               end else if (step_byte == CH_SLASH) begin
                  st_in.mode = MODE_LINE;
               end else begin
                  res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_SLASH); n_res = n_res + 2'd1;
                  st_in.mode = MODE_IDLE;
               end
            end
            MODE_BLOCK: begin
               if (step_byte == CH_STAR) st_in.mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (step_byte == CH_SLASH) st_in.mode = MODE_IDLE;
               else if (step_byte != CH_STAR) st_in.mode = MODE_BLOCK;
            end
            MODE_LINE: begin
               if (step_byte == CH_LF) st_in.mode = MODE_IDLE;
            end
            MODE_STR: begin
               if (sb.emit) begin
                  res_a[n_res[0]] = sb.r; n_res = n_res + 2'd1;
               end
               st_in.mode = sb.mode;
            end
            MODE_STR_ESC: begin
               st_in.mode = MODE_STR;
               case (step_byte)
                  CH_BSLASH: begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_BSLASH), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  CH_QUOTE: begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_QUOTE), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "n": begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_LF), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "r": begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_CR), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "t": begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_TAB), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "f": begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(8'h0C), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "b": begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(8'h08), ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  "u": begin
                     st_in.mode    = MODE_STR_HEX;
                     st_in.hex_cnt = 3'd0;
                     st_in.hex_acc = 16'd0;
                  end
                  default: begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(CH_BSLASH), ERR_NONE);
                     n_res = n_res + 2'd1;
                     if (sb.emit) begin
                        res_a[n_res[0]] = sb.r; n_res = n_res + 2'd1;
                     end
                     st_in.mode = sb.mode;
                  end
               endcase
            end
            MODE_STR_HEX: begin
               if (hex_ok) begin
                  st_in.hex_acc = hacc_new;
                  st_in.hex_cnt = hcnt_new;
                  if (hcnt_new >= 3'd4) begin
                     res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(hacc_new), ERR_NONE);
                     n_res = n_res + 2'd1;
                     st_in.mode = MODE_STR;
                  end
               end else begin
                  res_a[n_res[0]] = mk_res(KIND_STR_CHAR, VALUE_W'(st_ff.hex_acc), ERR_NONE);
                  n_res = n_res + 2'd1;
                  if (sb.emit) begin
                     res_a[n_res[0]] = sb.r; n_res = n_res + 2'd1;
                  end
                  st_in.mode = sb.mode;
               end
            end
            MODE_NUM: begin
               if (st_ff.fphase == 2'd1) begin
                  if (dig) begin
                     st_in.fphase = 2'd2;
                  end else begin
                     res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_DOT); n_res = n_res + 2'd1;
                     st_in.mode = MODE_IDLE;
                  end
               end else if (st_ff.fphase == 2'd0 && dig) begin
                  st_in.acc = (|mac[VALUE_W+3:VALUE_W]) ? VAL_MAX : mac[VALUE_W-1:0];
               end else if (st_ff.fphase == 2'd0 && step_byte == CH_DOT) begin
                  st_in.fphase = 2'd1;
               end else if (!dig) begin
                  res_a[n_res[0]] = mk_res((st_ff.fphase == 2'd0) ? KIND_INT : KIND_FLOAT,
                                           st_ff.acc, ERR_NONE);
                  n_res = n_res + 2'd1;
                  if (ib.emit) begin
                     res_a[n_res[0]] = ib.r; n_res = n_res + 2'd1;
                  end
                  st_in.mode = ib.mode;
                  if (ib.kw) begin
                     st_in.kw_which = ib.kw_which;
                     st_in.kw_prog  = 3'd1;
                  end
                  if (ib.num) begin
                     st_in.acc    = VALUE_W'(dval);
                     st_in.fphase = 2'd0;
                  end
               end
            end
            MODE_KW: begin
               if (p < kw_len(w) && step_byte == kw_char(w, p)) begin
                  st_in.kw_prog = p_new;
                  if (p_new >= kw_len(w)) begin
                     res_a[n_res[0]] = mk_res(4'(KIND_TRUE + {2'b00, w}), '0, ERR_NONE);
                     n_res = n_res + 2'd1;
                     st_in.mode = MODE_IDLE;
                  end
               end else begin
                  res_a[n_res[0]] = mk_res(KIND_ERROR, '0, ERR_UNKNOWN); n_res = n_res + 2'd1;
                  st_in.mode = MODE_IDLE;
               end
            end
            default: begin
               if (ib.emit) begin
                  res_a[n_res[0]] = ib.r; n_res = n_res + 2'd1;
               end
               st_in.mode = ib.mode;
               if (ib.kw) begin
                  st_in.kw_which = ib.kw_which;
                  st_in.kw_prog  = 3'd1;
               end
               if (ib.num) begin
                  st_in.acc    = VALUE_W'(dval);
                  st_in.fphase = 2'd0;
               end
            end
         endcase
      end

      if (n_res == 2'd1) res_a[0].last = 1'b1;
      if (n_res == 2'd2) res_a[1].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (step_fire) begin
         st_ff <= st_in;
      end
   end

   assign res0      = res_a[0];
   assign res1      = res_a[1];
   assign res_count = step_fire ? n_res : 2'd0;

endmodule

`default_nettype wire

[src/jbt_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// jbt_rsp_fifo: result word queue
// Takes zero to two result words per cycle, hands out one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        push_count,
   input  wire jbt_pkg::res_type  push0,
   input  wire jbt_pkg::res_type  push1,
   output logic                   space_ok,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output jbt_pkg::res_type       out_word
);
   import jbt_pkg::*;

   res_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;
   logic [FIFO_AW-1:0] wr_ptr_next;

   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_AW'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_AW'(push_count);
   assign rd_ptr_in   = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
   assign count_in    = count_ff + (FIFO_AW+1)'(push_count) - (FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff]   <= push0;
      if (push_count == 2'd2) mem_ff[wr_ptr_next] <= push1;
   end

   assign space_ok  = count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_word  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[src/json_byte_tokenizer.sv]
// An accepted req word passes the input register and then the result queue.
// One req word per cycle while the queue has room; two results of one word
// leave one per handshake through the single rsp port.
// The req side stalls only when the result queue lacks room for two words.
// Reset (synchronous, active high) returns the lexer to idle between tokens
// and empties the input stage and the result queue.
// ----------------------------------------------------------------------------
// json_byte_tokenizer: streaming JSON lexer, one byte per word
// Input register, single-pass lexer logic, result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module json_byte_tokenizer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_text_byte,
   input  wire logic                        req_is_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [3:0]                       rsp_token_kind,
   output logic [jbt_pkg::VALUE_W-1:0]      rsp_token_value,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last_of_run
);
   import jbt_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       space_ok;
   logic       step_fire;
   res_type    res0, res1, head;
   logic [1:0] res_count;

   assign step_fire = in_valid_ff && space_ok;
   assign req_ready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_end_ff  <= req_is_end;
      end
   end

   jbt_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .step_byte (in_byte_ff),
      .step_end  (in_end_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   jbt_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (head)
   );

   assign rsp_token_kind  = head.kind;
   assign rsp_token_value = head.value;
   assign rsp_error_code  = head.err;
   assign rsp_last_of_run = head.last;

endmodule

`default_nettype wire

[src/jbt_checker.sv]
// ----------------------------------------------------------------------------
// jbt_checker: port-level checks of the JSON byte tokenizer
// Watches the rsp channel and the field rules of each token kind.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [7:0]                  req_text_byte,
   input wire logic                        req_is_end,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [3:0]                  rsp_token_kind,
   input wire logic [jbt_pkg::VALUE_W-1:0] rsp_token_value,
   input wire logic [2:0]                  rsp_error_code,
   input wire logic                        rsp_last_of_run
);
   import jbt_pkg::*;

   logic unused_in;
   assign unused_in = req_valid ^ req_ready ^ (^req_text_byte) ^ req_is_end;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_value) && $stable(rsp_error_code)
         && $stable(rsp_last_of_run))
      else $error("rsp word changed while stalled");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("error code on a non-error token");

   a_err_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_ERROR |->
         rsp_error_code != ERR_NONE && rsp_error_code <= ERR_SLASH)
      else $error("error token without a valid code");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_INT && rsp_token_kind != KIND_FLOAT
         && rsp_token_kind != KIND_STR_CHAR |-> rsp_token_value == '0)
      else $error("value on a token that carries none");

   a_char_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_STR_CHAR |->
         rsp_token_value[VALUE_W-1:16] == '0)
      else $error("string code unit wider than 16 bits");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (.*);

`default_nettype wire
